### rtl/audio_ring_resampler_drc_unit_defines.svh
// Assertion macros for the audio ring resampler.
// Used by audio_ring_resampler_drc_unit; needs signals clk and rst_n in scope.
`ifndef AUDIO_RING_RESAMPLER_DRC_UNIT_DEFINES_SVH
`define AUDIO_RING_RESAMPLER_DRC_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define ARR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define ARR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/arrdrc_pkg.sv
// Types and constants shared by the audio ring resampler.
// No dependencies.
`timescale 1ns / 1ps

package arrdrc_pkg;

  localparam int FILL_W = 11;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 18;
  localparam int RATE_W = 18;
  localparam int ADJ_W  = 12;
  localparam int PHASE_W = 20;

  localparam logic [RATE_W-1:0] RATE_MAX   = 18'h3FFFF;
  localparam logic [RATE_W-1:0] RESET_RATE = 18'd48000;
  localparam logic [ADJ_W-1:0]  RESET_ADJ  = 12'd144;

  localparam int LOW_PCT   = 40;
  localparam int HIGH_PCT  = 60;
  localparam int PCT_SCALE = 100;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_RESAMPLE_MODE = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_INPUT_RATE    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_OUTPUT_RATE   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_RATE_ADJUST   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_BUFFER_LENGTH = 3'd4;

  // Resample modes; bit 1 set means rate control.
  localparam logic [1:0] RM_PASSTHROUGH = 2'd0;

  // Item kinds.
  localparam logic ITEM_PUSH = 1'b0;
  localparam logic ITEM_PULL = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic               batch_start;
  } in_item_t;

  typedef struct packed {
    logic               consumed;
    logic               stored;
    logic               full_res;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               underrun;
    logic [FILL_W-1:0]  fill_level;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RATE,
    S_PUSH,
    S_SETTLE,
    S_PULL,
    S_EMIT
  } arr_state_t;

endpackage

### rtl/audio_ring_resampler_drc_unit.sv
// Stereo audio ring buffer with nearest resampling and fill-based rate control.
// Depends on arrdrc_pkg and audio_ring_resampler_drc_unit_defines.svh.
`timescale 1ns / 1ps
`include "audio_ring_resampler_drc_unit_defines.svh"

// Usage:
// The input channel (in_valid, in_stall, in_item) carries push and pull items.
// A push offers one stereo frame; a pull asks for the oldest buffered frame.
// Every item gives exactly one result on the output channel (out_valid,
// out_stall, out_item). The configuration port (cfg_valid, cfg_ready,
// cfg_index, cfg_data) writes one register per handshake while idle.
// Steps: EVAL, RATE, PUSH, SETTLE, EMIT for a push; EVAL, PULL, EMIT for a pull.
// One item is in flight at a time; the sequencer walks it through the
// frame RAM (one read or one write per item, read data registered) and
// the phase/rate arithmetic, and a new item is accepted only after the
// last one has left its emit step.
// The result sits in an output register, so a new item is accepted while
// the receiver stalls; that item then waits in its last step until the
// output register frees up, and in_stall stays high meanwhile.
// Reset (synchronous, rst_n low) restores register defaults, empties the
// ring and clears the phase accumulator. The frame RAM is not cleared.
module audio_ring_resampler_drc_unit #(
  parameter int DEPTH = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  arrdrc_pkg::in_item_t                 in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output arrdrc_pkg::out_item_t                out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [arrdrc_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [arrdrc_pkg::CFG_DW-1:0]        cfg_data
);
  import arrdrc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LW = AW + 1;
  localparam int PW = LW + 7;
  localparam int RESET_LEN = (DEPTH < 2048) ? DEPTH : 2048;

  arr_state_t state_r, state_nxt;

  logic [1:0]         mode_r;
  logic [RATE_W-1:0]  input_rate_r;
  logic [RATE_W-1:0]  out_rate_r;
  logic [RATE_W-1:0]  adj_rate_r;
  logic [ADJ_W-1:0]   rate_adj_r;
  logic [LW-1:0]      len_r;

  logic [AW-1:0]      wr_r;
  logic [AW-1:0]      rd_r;
  logic [AW-1:0]      lim_r;
  logic [AW-1:0]      fill_r;
  logic [PHASE_W-1:0] phase_r;

  in_item_t           item_r;
  out_item_t          res_r;
  out_item_t          res_nxt;
  out_item_t          out_item_r;
  logic               out_valid_r;
  logic               low_r, high_r, full_r, stored_r;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_data_r;
  logic               mem_we;

  logic               passthrough;
  logic [RATE_W-1:0]  rate_sel;
  logic [RATE_W:0]    rate_sum;
  logic [RATE_W-1:0]  adj_calc;
  logic [PW-1:0]      fill_pct, len_low, len_high;
  logic [LW-1:0]      len_cfg;
  logic [11:0]        len_raw;
  logic               ring_full;
  logic               take_out;
  logic               emit_load;
  logic               settle_take;

  function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] i,
                                             input logic [LW-1:0] len);
    logic [LW-1:0] n;
    n = {1'b0, i} + LW'(1);
    return (n >= len) ? '0 : n[AW-1:0];
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign take_out  = out_valid_r && !out_stall;
  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  assign passthrough = (mode_r == RM_PASSTHROUGH);
  assign rate_sel    = mode_r[1] ? adj_rate_r : out_rate_r;
  assign ring_full   = (wr_r == lim_r);
  assign settle_take = !full_r && (passthrough || (phase_r >= PHASE_W'(rate_sel)));

  // floor(fill*100/len) < 40 iff fill*100 < 40*len; > 60 iff fill*100 >= 61*len.
  assign fill_pct = PW'(fill_r) * PW'(PCT_SCALE);
  assign len_low  = PW'(len_r) * PW'(LOW_PCT);
  assign len_high = PW'(len_r) * PW'(HIGH_PCT + 1);

  always_comb begin
    rate_sum = {1'b0, out_rate_r} + (RATE_W + 1)'(rate_adj_r);
    if (low_r) begin
      adj_calc = rate_sum[RATE_W] ? RATE_MAX : rate_sum[RATE_W-1:0];
    end else if (high_r) begin
      adj_calc = (out_rate_r > RATE_W'(rate_adj_r)) ?
                 out_rate_r - RATE_W'(rate_adj_r) : '0;
    end else begin
      adj_calc = out_rate_r;
    end
  end

  always_comb begin
    len_raw = cfg_data[11:0];
    if (len_raw < 12'd2) begin
      len_cfg = LW'(2);
    end else if (32'(len_raw) > 32'(DEPTH)) begin
      len_cfg = LW'(DEPTH);
    end else begin
      len_cfg = LW'(len_raw);
    end
  end

  // Result of the item in its settle or pull step.
  always_comb begin
    res_nxt = '0;
    if (state_r == S_PULL) begin
      if (rd_r != wr_r) begin
        res_nxt.left_out   = rd_data_r[15:0];
        res_nxt.right_out  = rd_data_r[31:16];
        res_nxt.fill_level = FILL_W'(fill_r - AW'(1));
      end else begin
        res_nxt.underrun   = 1'b1;
        res_nxt.fill_level = FILL_W'(fill_r);
      end
    end else begin
      res_nxt.consumed   = settle_take;
      res_nxt.stored     = stored_r;
      res_nxt.full_res   = full_r;
      res_nxt.fill_level = FILL_W'(fill_r);
    end
  end

  assign mem_we = (state_r == S_PUSH) && !ring_full &&
                  (passthrough || (phase_r < PHASE_W'(rate_sel)));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_r] <= {item_r.right_in, item_r.left_in};
    end
    rd_data_r <= mem[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_EVAL;
      S_EVAL:   state_nxt = (item_r.mode == ITEM_PULL) ? S_PULL : S_RATE;
      S_RATE:   state_nxt = S_PUSH;
      S_PUSH:   state_nxt = S_SETTLE;
      S_SETTLE: state_nxt = S_EMIT;
      S_PULL:   state_nxt = S_EMIT;
      S_EMIT:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= RM_PASSTHROUGH;
      input_rate_r <= RESET_RATE;
      out_rate_r   <= RESET_RATE;
      adj_rate_r   <= RESET_RATE;
      rate_adj_r   <= RESET_ADJ;
      len_r        <= LW'(RESET_LEN);
      wr_r         <= '0;
      rd_r         <= '0;
      lim_r        <= AW'(RESET_LEN - 1);
      fill_r       <= '0;
      phase_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit_load) begin
        out_item_r  <= res_r;
        out_valid_r <= 1'b1;
      end else if (take_out) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RESAMPLE_MODE: mode_r <= cfg_data[1:0];
          CFG_INPUT_RATE:    input_rate_r <= cfg_data[RATE_W-1:0];
          CFG_OUTPUT_RATE: begin
            out_rate_r <= cfg_data[RATE_W-1:0];
            adj_rate_r <= cfg_data[RATE_W-1:0];
          end
          CFG_RATE_ADJUST:   rate_adj_r <= cfg_data[ADJ_W-1:0];
          CFG_BUFFER_LENGTH: begin
            len_r  <= len_cfg;
            wr_r   <= '0;
            rd_r   <= '0;
            lim_r  <= AW'(len_cfg - LW'(1));
            fill_r <= '0;
          end
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) item_r <= in_item;
        end
        S_EVAL: begin
          low_r  <= (fill_pct < len_low);
          high_r <= (fill_pct >= len_high);
        end
        S_RATE: begin
          // The nudge comes before the full check, so a refused push keeps it.
          if (item_r.mode == ITEM_PUSH && mode_r[1] && item_r.batch_start) begin
            adj_rate_r <= adj_calc;
          end
        end
        S_PUSH: begin
          full_r   <= ring_full;
          stored_r <= mem_we;
          if (mem_we) begin
            wr_r   <= step_idx(wr_r, len_r);
            fill_r <= fill_r + AW'(1);
          end
          if (mem_we && !passthrough) begin
            phase_r <= phase_r + PHASE_W'(input_rate_r);
          end
        end
        S_SETTLE: begin
          res_r <= res_nxt;
          if (settle_take && !passthrough) begin
            phase_r <= phase_r - PHASE_W'(rate_sel);
          end
        end
        S_PULL: begin
          res_r <= res_nxt;
          if (rd_r != wr_r) begin
            lim_r  <= rd_r;
            rd_r   <= step_idx(rd_r, len_r);
            fill_r <= fill_r - AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `ARR_ASSERT(a_fill_below_len, {1'b0, fill_r} < len_r, "fill count reached buffer length")
  `ARR_ASSERT(a_ptrs_in_range, ({1'b0, wr_r} < len_r) && ({1'b0, rd_r} < len_r), "ring pointer out of range")
  `ARR_ASSERT(a_empty_consistent, (wr_r == rd_r) == (fill_r == '0), "fill count disagrees with pointers")
  `ARR_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == S_EVAL, "accepted item not started")
  `ARR_ASSERT(a_result_from_emit, $rose(out_valid_r) |-> $past(state_r == S_EMIT), "result raised outside emit step")

endmodule
